@@ src/fcr_pkg.sv @@
// Package for the framed command recognizer.
// Holds buffer sizing, framing marks, command codes and keyword tables.
// No dependencies.
package fcr_pkg;

    localparam int BUFFER_DEPTH = 10;
    localparam int IDX_W = $clog2(BUFFER_DEPTH);

    localparam logic [7:0] START_MARK = 8'h31;
    localparam logic [7:0] END_MARK = 8'h32;
    localparam logic [7:0] NUL_BYTE = 8'h00;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_HK = 2'd1,
        CMD_SAD = 2'd2,
        CMD_MSG = 2'd3
    } cmd_id_t;

    typedef logic [7:0] store_t [BUFFER_DEPTH];

    // Keywords include their terminating zero.
    localparam int KW_HK_LEN = 3;
    localparam int KW_SAD_LEN = 9;
    localparam int KW_MSG_LEN = 4;

    localparam logic [7:0] KW_HK [KW_HK_LEN] = '{8'h68, 8'h6b, 8'h00};
    localparam logic [7:0] KW_SAD [KW_SAD_LEN] =
        '{8'h69, 8'h20, 8'h61, 8'h6d, 8'h20, 8'h73, 8'h61, 8'h64, 8'h00};
    localparam logic [7:0] KW_MSG [KW_MSG_LEN] = '{8'h6d, 8'h73, 8'h67, 8'h00};

endpackage

@@ src/fcr_match.sv @@
// Keyword classifier for the framed command recognizer.
// Compares the command buffer against the three keywords; uses fcr_pkg.
module fcr_match (
    input  fcr_pkg::store_t  store,
    output fcr_pkg::cmd_id_t cmd_id
);

    logic hk_hit;
    logic sad_hit;
    logic msg_hit;

    // Entries past the keyword end are ignored; the terminator entry must be zero.
    always_comb
    begin
        hk_hit = 1'b1;
        sad_hit = 1'b1;
        msg_hit = 1'b1;
        for (int i = 0; i < fcr_pkg::KW_HK_LEN && i < fcr_pkg::BUFFER_DEPTH; i++)
        begin
            if (store[i] != fcr_pkg::KW_HK[i])
            begin
                hk_hit = 1'b0;
            end
        end
        for (int i = 0; i < fcr_pkg::KW_SAD_LEN && i < fcr_pkg::BUFFER_DEPTH; i++)
        begin
            if (store[i] != fcr_pkg::KW_SAD[i])
            begin
                sad_hit = 1'b0;
            end
        end
        for (int i = 0; i < fcr_pkg::KW_MSG_LEN && i < fcr_pkg::BUFFER_DEPTH; i++)
        begin
            if (store[i] != fcr_pkg::KW_MSG[i])
            begin
                msg_hit = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (hk_hit)
        begin
            cmd_id = fcr_pkg::CMD_HK;
        end
        else if (sad_hit)
        begin
            cmd_id = fcr_pkg::CMD_SAD;
        end
        else if (msg_hit)
        begin
            cmd_id = fcr_pkg::CMD_MSG;
        end
        else
        begin
            cmd_id = fcr_pkg::CMD_NONE;
        end
    end

endmodule

@@ src/framed_command_recognizer_unit.sv @@
// Top level of the framed command recognizer.
// Holds the input register, framing state, command buffer and result register;
// uses fcr_pkg and fcr_match.
//
//  Channel | Handshake           | Payload
//  --------+---------------------+-------------------------------------------------
//  in      | in_valid, in_stall  | rx_byte
//  out     | out_valid, out_stall| echo_valid, echo_byte, command_done, command_id
//
// Each byte passes from the input register through the classifier into the
// result register.
// One byte per cycle is sustained while the result is not stalled; the framing state updates on each accepted byte.
// Reset clears the flags, the count, the write index and the command buffer.
// A stalled result holds the input register, and in_stall rises only then.
module framed_command_recognizer_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       echo_valid,
    output logic [7:0] echo_byte,
    output logic       command_done,
    output logic [1:0] command_id
);

    logic                     in_vld_reg;
    logic [7:0]               in_byte_reg;
    logic                     out_vld_reg;
    logic                     echo_vld_reg;
    logic [7:0]               echo_byte_reg;
    logic                     done_reg;
    fcr_pkg::cmd_id_t         id_reg;

    logic                     listening_reg;
    logic                     listening_next;
    logic                     end_seen_reg;
    logic                     end_seen_next;
    logic [7:0]               write_count_reg;
    logic [7:0]               write_count_next;
    logic [fcr_pkg::IDX_W-1:0] wr_idx_reg;
    logic [fcr_pkg::IDX_W-1:0] wr_idx_next;
    fcr_pkg::store_t          store_reg;

    logic                     advance;
    logic                     fire;
    logic                     is_start;
    logic                     is_end;
    logic                     store_en;
    logic                     done;
    fcr_pkg::cmd_id_t         match_id;

    assign advance = !out_vld_reg || !out_stall;
    assign fire = in_vld_reg && advance;
    assign in_stall = in_vld_reg && !advance;

    assign is_start = (in_byte_reg == fcr_pkg::START_MARK);
    assign is_end = (in_byte_reg == fcr_pkg::END_MARK);

    // The completing byte is always a mark, so the buffer is final when classified.
    fcr_match u_match (
        .store  (store_reg),
        .cmd_id (match_id)
    );

    always_comb
    begin
        listening_next = listening_reg | is_start;
        end_seen_next = end_seen_reg | is_end;
        store_en = listening_next && (in_byte_reg != fcr_pkg::NUL_BYTE)
                   && !is_start && !is_end;
        done = listening_next && end_seen_next;
        write_count_next = write_count_reg;
        wr_idx_next = wr_idx_reg;
        if (store_en)
        begin
            write_count_next = write_count_reg + 8'd1;
            // The index follows the 8-bit count modulo the depth, including its wrap.
            if (write_count_reg == 8'hff
                || wr_idx_reg == fcr_pkg::IDX_W'(fcr_pkg::BUFFER_DEPTH - 1))
            begin
                wr_idx_next = '0;
            end
            else
            begin
                wr_idx_next = wr_idx_reg + fcr_pkg::IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listening_reg <= 1'b0;
            end_seen_reg <= 1'b0;
            write_count_reg <= '0;
            wr_idx_reg <= '0;
            for (int i = 0; i < fcr_pkg::BUFFER_DEPTH; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            if (done)
            begin
                listening_reg <= 1'b0;
                end_seen_reg <= 1'b0;
                write_count_reg <= '0;
                wr_idx_reg <= '0;
                for (int i = 0; i < fcr_pkg::BUFFER_DEPTH; i++)
                begin
                    store_reg[i] <= '0;
                end
            end
            else
            begin
                listening_reg <= listening_next;
                end_seen_reg <= end_seen_next;
                write_count_reg <= write_count_next;
                wr_idx_reg <= wr_idx_next;
                if (store_en)
                begin
                    store_reg[wr_idx_reg] <= in_byte_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            echo_vld_reg <= !done;
            echo_byte_reg <= in_byte_reg;
            done_reg <= done;
            id_reg <= done ? match_id : fcr_pkg::CMD_NONE;
        end
    end

    assign out_valid = out_vld_reg;
    assign echo_valid = echo_vld_reg;
    assign echo_byte = echo_byte_reg;
    assign command_done = done_reg;
    assign command_id = id_reg;

endmodule

@@ src/fcr_checker.sv @@
// Port-level checker for the framed command recognizer, with its bind.
// Watches the top level's ports only; uses fcr_pkg.
module fcr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       echo_valid,
    input logic [7:0] echo_byte,
    input logic       command_done,
    input logic [1:0] command_id
);

    // A stalled result transfer keeps its echo byte, completion flag and command code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(echo_byte)
                                   && $stable(command_done) && $stable(command_id))
    else $error("stalled result changed");

    // A completing byte is never echoed, and every other byte is.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> echo_valid != command_done)
    else $error("echo and completion disagree");

    // Only a start or end mark can complete a command.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command_done |->
            echo_byte == fcr_pkg::START_MARK || echo_byte == fcr_pkg::END_MARK)
    else $error("command completed by a non-mark byte");

    // The command code is zero outside a completion.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !command_done |-> command_id == fcr_pkg::CMD_NONE)
    else $error("command id without completion");

endmodule

bind framed_command_recognizer_unit fcr_checker u_fcr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .echo_valid   (echo_valid),
    .echo_byte    (echo_byte),
    .command_done (command_done),
    .command_id   (command_id)
);

@@ tb/framed_command_recognizer_unit_tb.sv @@
`timescale 1ns / 1ps
// Testbench for framed_command_recognizer_unit: a directed table of framed commands, then
// random frames; each result is checked against a typed row or a framing state model.
// Depends on fcr_pkg and the framed_command_recognizer_unit RTL.
module framed_command_recognizer_unit_tb;

    typedef struct packed {
        logic             echo_valid;
        logic [7:0]       echo_byte;
        logic             command_done;
        fcr_pkg::cmd_id_t command_id;
    } echo_result_t;

    typedef struct packed {
        logic [7:0]   rx;
        logic         typed;
        echo_result_t want;
    } stim_row_t;

    localparam int RANDOM_CHARS = 170;
    localparam int DIRECTED_COUNT = 24;
    localparam echo_result_t NO_TYPED = '{1'b0, 8'h00, 1'b0, fcr_pkg::CMD_NONE};

    localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{8'h00, 1'b1, '{1'b1, 8'h00, 1'b0, fcr_pkg::CMD_NONE}},
        '{8'hff, 1'b1, '{1'b1, 8'hff, 1'b0, fcr_pkg::CMD_NONE}},
        '{fcr_pkg::START_MARK, 1'b0, NO_TYPED},
        '{8'h68, 1'b0, NO_TYPED},
        '{8'h6b, 1'b0, NO_TYPED},
        '{fcr_pkg::NUL_BYTE, 1'b0, NO_TYPED},
        '{fcr_pkg::END_MARK, 1'b1, '{1'b0, fcr_pkg::END_MARK, 1'b1, fcr_pkg::CMD_HK}},
        '{fcr_pkg::END_MARK, 1'b1, '{1'b1, fcr_pkg::END_MARK, 1'b0, fcr_pkg::CMD_NONE}},
        '{fcr_pkg::START_MARK, 1'b1,
          '{1'b0, fcr_pkg::START_MARK, 1'b1, fcr_pkg::CMD_NONE}},
        '{fcr_pkg::START_MARK, 1'b0, NO_TYPED},
        '{8'h6d, 1'b0, NO_TYPED},
        '{8'h73, 1'b0, NO_TYPED},
        '{8'h67, 1'b0, NO_TYPED},
        '{fcr_pkg::END_MARK, 1'b1, '{1'b0, fcr_pkg::END_MARK, 1'b1, fcr_pkg::CMD_MSG}},
        '{fcr_pkg::START_MARK, 1'b0, NO_TYPED},
        '{8'h69, 1'b0, NO_TYPED},
        '{8'h20, 1'b0, NO_TYPED},
        '{8'h61, 1'b0, NO_TYPED},
        '{8'h6d, 1'b0, NO_TYPED},
        '{8'h20, 1'b0, NO_TYPED},
        '{8'h73, 1'b0, NO_TYPED},
        '{8'h61, 1'b0, NO_TYPED},
        '{8'h64, 1'b0, NO_TYPED},
        '{fcr_pkg::END_MARK, 1'b1, '{1'b0, fcr_pkg::END_MARK, 1'b1, fcr_pkg::CMD_SAD}}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       command_done;
    logic [1:0] command_id;

    logic       listening = 1'b0;
    logic       end_seen = 1'b0;
    logic [7:0] write_count = 8'h00;
    logic [7:0] command_store [fcr_pkg::BUFFER_DEPTH] = '{default: 8'h00};

    echo_result_t expected_echoes [$];
    logic [7:0]   frame_chars [$];
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           random_sent = 0;
    int           mismatch_count = 0;

    framed_command_recognizer_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .echo_valid   (echo_valid),
        .echo_byte    (echo_byte),
        .command_done (command_done),
        .command_id   (command_id)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    function automatic logic keyword_hit(input string word);
        logic [7:0] ch;
        for (int i = 0; i <= word.len() && i < fcr_pkg::BUFFER_DEPTH; i++)
        begin
            ch = (i < word.len()) ? 8'(word[i]) : fcr_pkg::NUL_BYTE;
            if (ch != command_store[i])
                return 1'b0;
            if (ch == fcr_pkg::NUL_BYTE)
                return 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic echo_result_t decode_char(input logic [7:0] ch);
        echo_result_t r;
        if (ch == fcr_pkg::START_MARK)
            listening = 1'b1;
        if (ch == fcr_pkg::END_MARK)
            end_seen = 1'b1;
        if (listening && ch != fcr_pkg::NUL_BYTE && ch != fcr_pkg::START_MARK
            && ch != fcr_pkg::END_MARK)
        begin
            command_store[write_count % fcr_pkg::BUFFER_DEPTH] = ch;
            write_count = write_count + 8'd1;
        end
        r = '{1'b1, ch, 1'b0, fcr_pkg::CMD_NONE};
        if (listening && end_seen)
        begin
            if (keyword_hit("hk"))
                r.command_id = fcr_pkg::CMD_HK;
            else if (keyword_hit("i am sad"))
                r.command_id = fcr_pkg::CMD_SAD;
            else if (keyword_hit("msg"))
                r.command_id = fcr_pkg::CMD_MSG;
            listening = 1'b0;
            end_seen = 1'b0;
            write_count = 8'h00;
            for (int i = 0; i < fcr_pkg::BUFFER_DEPTH; i++)
                command_store[i] = 8'h00;
            r.echo_valid = 1'b0;
            r.command_done = 1'b1;
        end
        return r;
    endfunction

    task automatic send_char(input logic [7:0] ch, input logic typed, input echo_result_t want);
        echo_result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= ch;
        do
            @(posedge clk);
        while (in_stall);
        predicted = decode_char(ch);
        expected_echoes.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic send_frame();
        while (frame_chars.size() != 0)
        begin
            send_char(frame_chars.pop_front(), 1'b0, NO_TYPED);
            random_sent++;
        end
    endtask

    task automatic build_frame();
        int    kind;
        int    n;
        string word;
        kind = $urandom_range(0, 99);
        case ($urandom_range(0, 2))
            0: word = "hk";
            1: word = "i am sad";
            default: word = "msg";
        endcase
        if (kind < 50)
        begin
            frame_chars.push_back(fcr_pkg::START_MARK);
            for (int i = 0; i < word.len(); i++)
            begin
                if ($urandom_range(0, 99) < 10)
                    frame_chars.push_back(fcr_pkg::NUL_BYTE);
                if ($urandom_range(0, 99) < 8)
                    frame_chars.push_back(8'($urandom_range(1, 255)));
                else
                    frame_chars.push_back(8'(word[i]));
            end
            if ($urandom_range(0, 99) < 15)
                frame_chars.push_back(8'($urandom_range(97, 122)));
            if ($urandom_range(0, 99) < 15)
                void'(frame_chars.pop_back());
            frame_chars.push_back(fcr_pkg::END_MARK);
        end
        else if (kind < 65)
        begin
            frame_chars.push_back(fcr_pkg::START_MARK);
            n = $urandom_range(0, 14);
            repeat (n)
                frame_chars.push_back(8'($urandom_range(0, 255)));
            frame_chars.push_back(fcr_pkg::END_MARK);
        end
        else if (kind < 75)
        begin
            frame_chars.push_back(fcr_pkg::START_MARK);
            n = $urandom_range(8, 13);
            repeat (n)
                frame_chars.push_back(8'($urandom_range(97, 122)));
            for (int i = 0; i < word.len(); i++)
                frame_chars.push_back(8'(word[i]));
            frame_chars.push_back(fcr_pkg::END_MARK);
        end
        else if (kind < 85)
        begin
            frame_chars.push_back(fcr_pkg::END_MARK);
            n = $urandom_range(0, 3);
            repeat (n)
                frame_chars.push_back(8'($urandom_range(0, 255)));
            frame_chars.push_back(fcr_pkg::START_MARK);
        end
        else
        begin
            n = $urandom_range(1, 6);
            repeat (n)
                frame_chars.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    always @(posedge clk)
    begin : result_check
        echo_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_echoes.size() == 0)
            begin
                $error("unexpected transfer: echo_byte %h", echo_byte);
                mismatch_count++;
            end
            else
            begin
                want = expected_echoes.pop_front();
                if (echo_valid !== want.echo_valid)
                begin
                    $error("echo_valid: expected %b, got %b", want.echo_valid, echo_valid);
                    mismatch_count++;
                end
                if (echo_byte !== want.echo_byte)
                begin
                    $error("echo_byte: expected %h, got %h", want.echo_byte, echo_byte);
                    mismatch_count++;
                end
                if (command_done !== want.command_done)
                begin
                    $error("command_done: expected %b, got %b", want.command_done, command_done);
                    mismatch_count++;
                end
                if (command_id !== want.command_id)
                begin
                    $error("command_id: expected %0d, got %0d", want.command_id, command_id);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_idle_pct = 18;
        recv_idle_pct = 60;
        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_char(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

        while (random_sent < RANDOM_CHARS / 3)
        begin
            build_frame();
            send_frame();
        end
        send_idle_pct = 60;
        recv_idle_pct = 18;
        while (random_sent < 2 * RANDOM_CHARS / 3)
        begin
            build_frame();
            send_frame();
        end
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // A frame long enough to wrap the write count past 255.
        frame_chars.push_back(fcr_pkg::START_MARK);
        repeat (258)
            frame_chars.push_back(8'($urandom_range(97, 122)));
        frame_chars.push_back(fcr_pkg::END_MARK);
        send_frame();
        random_sent = 2 * RANDOM_CHARS / 3;
        while (random_sent < RANDOM_CHARS)
        begin
            build_frame();
            send_frame();
        end
        in_valid <= 1'b0;

        for (int n = 0; n < 1000 && expected_echoes.size() != 0; n++)
            @(posedge clk);
        if (expected_echoes.size() != 0)
        begin
            $error("%0d transfers never arrived", expected_echoes.size());
            mismatch_count++;
        end
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

@@ framed_command_recognizer_unit.f @@
src/fcr_pkg.sv
src/fcr_match.sv
src/framed_command_recognizer_unit.sv
src/fcr_checker.sv
tb/framed_command_recognizer_unit_tb.sv
